// ===== src/rtc_bcd_date_to_seconds_defines.svh =====
// ----------------------------------------------------------------------------
// RTC date converter assertion macros
// Clocked, reset-qualified property checks shared by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef RTC_BCD_DATE_TO_SECONDS_DEFINES_SVH
`define RTC_BCD_DATE_TO_SECONDS_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define RTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define RTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rtcb2s_pkg.sv =====
// ----------------------------------------------------------------------------
// RTC date converter package
// Payload types, status codes, calendar constants and BCD helpers.
// ----------------------------------------------------------------------------
package rtcb2s_pkg;

  typedef struct packed {
    logic [7:0] status_a;
    logic [7:0] year_bcd;
    logic [7:0] month_bcd;
    logic [7:0] day_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] minute_bcd;
    logic [7:0] second_bcd;
  } rtcb2s_in_t;

  typedef struct packed {
    logic [31:0] seconds;
    logic [1:0]  status;
  } rtcb2s_out_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_CLOCK = 2'd1;
  localparam logic [1:0] STATUS_BUSY     = 2'd2;

  localparam logic [0:0] CFG_DST_FIRST = 1'b0;
  localparam logic [0:0] CFG_DST_LAST  = 1'b1;

  localparam logic [8:0] DST_FIRST_RESET = 9'd119;
  localparam logic [8:0] DST_LAST_RESET  = 9'd303;

  localparam logic [7:0] SA_NONE_LOW  = 8'h00;
  localparam logic [7:0] SA_NONE_HIGH = 8'hFF;

  localparam logic [11:0] CENTURY_BASE = 12'd1900;
  localparam logic [11:0] WINDOW_START = 12'd1970;
  localparam logic [11:0] CENTURY_STEP = 12'd100;
  localparam logic [11:0] EPOCH_YEAR   = 12'd1990;

  localparam logic [31:0] SEC_PER_MIN       = 32'd60;
  localparam logic [31:0] SEC_PER_HOUR      = 32'd3600;
  localparam logic [31:0] SEC_PER_DAY       = 32'd86400;
  localparam logic [31:0] SEC_PER_YEAR      = 32'd365 * SEC_PER_DAY;
  localparam logic [31:0] SEC_PER_LEAP_YEAR = 32'd366 * SEC_PER_DAY;

  // Packed BCD byte to binary, no digit check: hi * 10 + lo.
  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0000, b[7:4]};
    lo = {4'b0000, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // Length of month m (1 to 12); zero elsewhere.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                      d = 5'd30;
      4'd2:                                         d = leap ? 5'd29 : 5'd28;
      default:                                      d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/rtc_bcd_date_to_seconds.sv =====
// ----------------------------------------------------------------------------
// RTC BCD date to seconds since 1990
// Command channel: drive date and pulse start while busy is low; the item is
// taken at that edge. One result item comes back on result, marked by valid
// for exactly one cycle; the receiver cannot stall it.
// A snapshot with no clock (status 0x00 or 0xFF) or with the update bit set
// returns seconds zero and its status code on the cycle after acceptance.
// Otherwise one 32-bit accumulator adder is shared by a small sequencer
// that steps through a year loop from 1990 (one year a cycle), a month loop
// over the months before the given one (up to 12), and then the day, day
// adjust, hour, minute, second and DST terms before valid is shown.
// busy stays high throughout; a new start may be given in the cycle that
// valid is shown. The user must write the DST window bounds on cfg_write/
// cfg_index/cfg_data only while idle; the block does not enforce this.
// Synchronous reset idles the sequencer, drops any pending result and
// restores the window to days 119..303.
// ----------------------------------------------------------------------------
`include "rtc_bcd_date_to_seconds_defines.svh"

module rtc_bcd_date_to_seconds
  import rtcb2s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  rtcb2s_in_t  date,
  output logic        valid,
  output rtcb2s_out_t result,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_YEAR  = 4'b0010,
    ST_MONTH = 4'b0100,
    ST_TERMS = 4'b1000
  } state_t;

  localparam logic [2:0] TERM_DAY     = 3'd0;
  localparam logic [2:0] TERM_DAY_ADJ = 3'd1;
  localparam logic [2:0] TERM_HOUR    = 3'd2;
  localparam logic [2:0] TERM_MIN     = 3'd3;
  localparam logic [2:0] TERM_SEC     = 3'd4;
  localparam logic [2:0] TERM_DST     = 3'd5;

  state_t      state;
  logic [8:0]  dst_first;
  logic [8:0]  dst_last;
  logic [11:0] year_full;
  logic [7:0]  month_v;
  logic [7:0]  day_v;
  logic [7:0]  hour_v;
  logic [7:0]  minute_v;
  logic [7:0]  second_v;
  logic [11:0] yr;
  logic [3:0]  mon;
  logic [8:0]  doy_month;
  logic [2:0]  term;
  logic [31:0] acc;

  logic [11:0] year_raw;
  logic [11:0] year_win;
  logic        leap;
  logic [4:0]  mdays;
  logic        month_more;
  logic [9:0]  doy;
  logic        doy_valid;
  logic        in_window;
  logic [31:0] addend;
  logic [31:0] sum;

  assign busy = (state != ST_IDLE);

  // Window the two-digit year to 1970..2069.
  assign year_raw = {4'b0000, bcd_value(date.year_bcd)} + CENTURY_BASE;
  assign year_win = (year_raw < WINDOW_START) ? year_raw + CENTURY_STEP : year_raw;

  assign leap       = (year_full[1:0] == 2'b00);
  assign mdays      = month_len(mon, leap);
  assign month_more = ({4'b0000, mon} < month_v) && (mon <= 4'd12);

  // Day of year; day zero borrows from the months before it, and with no
  // months before it the wrapped value lies far beyond any window bound.
  always_comb begin
    if (day_v == 8'd0) begin
      doy_valid = (doy_month != 9'd0);
      doy       = {1'b0, doy_month} - 10'd1;
    end else begin
      doy_valid = 1'b1;
      doy       = {1'b0, doy_month} + {2'b00, day_v} - 10'd1;
    end
  end

  assign in_window = doy_valid && (doy >= {1'b0, dst_first}) && (doy <= {1'b0, dst_last});

  // Shared adder operand.
  always_comb begin
    addend = '0;
    case (state)
      ST_YEAR: begin
        addend = (yr[1:0] == 2'b00) ? SEC_PER_LEAP_YEAR : SEC_PER_YEAR;
      end
      ST_MONTH: begin
        addend = 32'(mdays) * SEC_PER_DAY;
      end
      ST_TERMS: begin
        case (term)
          TERM_DAY:     addend = 32'(day_v) * SEC_PER_DAY;
          TERM_DAY_ADJ: addend = -SEC_PER_DAY;
          TERM_HOUR:    addend = 32'(hour_v) * SEC_PER_HOUR;
          TERM_MIN:     addend = 32'(minute_v) * SEC_PER_MIN;
          TERM_SEC:     addend = 32'(second_v);
          TERM_DST:     addend = in_window ? -SEC_PER_HOUR : 32'd0;
          default:      addend = '0;
        endcase
      end
      default: addend = '0;
    endcase
  end

  assign sum = acc + addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_first <= DST_FIRST_RESET;
      dst_last  <= DST_LAST_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DST_FIRST: dst_first <= cfg_data;
        CFG_DST_LAST:  dst_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (date.status_a == SA_NONE_LOW || date.status_a == SA_NONE_HIGH) begin
              result <= '{seconds: 32'd0, status: STATUS_NO_CLOCK};
              valid  <= 1'b1;
            end else if (date.status_a[7]) begin
              result <= '{seconds: 32'd0, status: STATUS_BUSY};
              valid  <= 1'b1;
            end else begin
              year_full <= year_win;
              month_v   <= bcd_value(date.month_bcd);
              day_v     <= bcd_value(date.day_bcd);
              hour_v    <= bcd_value(date.hour_bcd);
              minute_v  <= bcd_value(date.minute_bcd);
              second_v  <= bcd_value(date.second_bcd);
              yr        <= EPOCH_YEAR;
              acc       <= '0;
              state     <= ST_YEAR;
            end
          end
        end
        ST_YEAR: begin
          if (yr < year_full) begin
            acc <= sum;
            yr  <= yr + 12'd1;
          end else begin
            mon       <= 4'd1;
            doy_month <= '0;
            state     <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (month_more) begin
            acc       <= sum;
            doy_month <= doy_month + {4'b0000, mdays};
            mon       <= mon + 4'd1;
          end else begin
            term  <= TERM_DAY;
            state <= ST_TERMS;
          end
        end
        ST_TERMS: begin
          acc <= sum;
          if (term == TERM_DST) begin
            result <= '{seconds: sum, status: STATUS_OK};
            valid  <= 1'b1;
            state  <= ST_IDLE;
          end else begin
            term <= term + 3'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `RTC_ASSERT(a_valid_idle, valid |-> !busy, "result shown while sequencer busy")
  `RTC_ASSERT(a_error_zero, (valid && result.status != STATUS_OK) |-> (result.seconds == 32'd0), "error result carries nonzero seconds")
  `RTC_ASSERT_NEXT(a_no_clock, start && !busy && (date.status_a == SA_NONE_LOW || date.status_a == SA_NONE_HIGH), valid && result.status == STATUS_NO_CLOCK, "no-clock item not answered next cycle")
  `RTC_ASSERT_NEXT(a_upd_busy, start && !busy && date.status_a[7] && date.status_a != SA_NONE_HIGH, valid && result.status == STATUS_BUSY, "update-in-progress item not answered next cycle")

endmodule
